// ===== rtl/ckpq_pkg.sv =====
// Package: constants, types and ordering functions of the event priority queue.
`default_nettype none

package ckpq_pkg;

    // Sizing
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned TAG_BITS = 16;
    localparam int unsigned TagW     = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int unsigned IdxW     = $clog2(CAPACITY);
    localparam int unsigned CntW     = $clog2(CAPACITY + 1);
    localparam int unsigned SeqW     = 32;

    // Field limits
    localparam logic [4:0] HourMax   = 5'd23;
    localparam logic [5:0] MinuteMax = 6'd59;

    // Operation codes
    localparam logic OpPush = 1'b0;
    localparam logic OpPop  = 1'b1;

    // Kind codes
    localparam logic [1:0] KindSystem  = 2'd0;
    localparam logic [1:0] KindMessage = 2'd1;
    localparam logic [1:0] KindApp     = 2'd2;
    localparam logic [1:0] KindUnused  = 2'd3;

    // Kind ranks, higher leaves first
    localparam logic [1:0] RankMessage = 2'd3;
    localparam logic [1:0] RankSystem  = 2'd2;
    localparam logic [1:0] RankApp     = 2'd1;

    // Status codes
    localparam logic [1:0] StatusOk    = 2'd0;
    localparam logic [1:0] StatusEmpty = 2'd1;
    localparam logic [1:0] StatusFull  = 2'd2;

    // Stored record
    typedef struct packed {
        logic            urgent;
        logic [4:0]      hour;
        logic [5:0]      minute;
        logic [1:0]      kind;
        logic [TagW-1:0] tag;
        logic [SeqW-1:0] seq;
    } t_rec;

    localparam int unsigned RecW = $bits(t_rec);

    // Result held for the output channel
    typedef struct packed {
        logic [1:0]      status;
        logic            urgent;
        logic [4:0]      hour;
        logic [5:0]      minute;
        logic [1:0]      kind;
        logic [TagW-1:0] tag;
        logic [4:0]      occupancy;
    } t_rsp;

    // Control from the sequencer to the best-entry tracker
    typedef struct packed {
        logic cmp_en;
        logic first;
    } t_best_ctl;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_DRAIN,
        S_MOVE,
        S_FINISH
    } t_state;

    function automatic logic [1:0] kind_rank(input logic [1:0] kind);
        logic [1:0] rank;
        rank = RankApp;
        if (kind == KindMessage) begin
            rank = RankMessage;
        end else if (kind == KindSystem) begin
            rank = RankSystem;
        end
        return rank;
    endfunction

    // True when record a leaves the queue before record b
    function automatic logic goes_first(input t_rec a, input t_rec b);
        logic       ia;
        logic       ib;
        logic [1:0] ra;
        logic [1:0] rb;
        logic       res;
        ia = a.urgent && (a.kind == KindSystem);
        ib = b.urgent && (b.kind == KindSystem);
        ra = kind_rank(a.kind);
        rb = kind_rank(b.kind);
        if (ia != ib) begin
            res = ia;
        end else if (a.hour != b.hour) begin
            res = (a.hour < b.hour);
        end else if (a.minute != b.minute) begin
            res = (a.minute < b.minute);
        end else if (ra != rb) begin
            res = (ra > rb);
        end else begin
            res = (a.seq < b.seq);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ckpq_if.sv =====
// Interfaces: request and response channels of the event priority queue.
`default_nettype none

interface ckpq_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        urgent;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [1:0]  kind;
    logic [15:0] tag;

    modport source (output valid, op, urgent, hour, minute, kind, tag, input ready);
    modport sink   (input valid, op, urgent, hour, minute, kind, tag, output ready);
endinterface

interface ckpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        out_urgent;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [1:0]  out_kind;
    logic [15:0] out_tag;
    logic [4:0]  occupancy;

    modport source (output valid, status, out_urgent, out_hour, out_minute, out_kind,
                    out_tag, occupancy, input ready);
    modport sink   (input valid, status, out_urgent, out_hour, out_minute, out_kind,
                    out_tag, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/ckpq_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module ckpq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then read old contents at the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ckpq_best.sv =====
// Best-entry tracker: keeps the highest-priority record seen during a scan.
`default_nettype none

module ckpq_best (
    input  wire logic                        i_clk,
    input  wire ckpq_pkg::t_best_ctl         i_ctl,
    input  wire ckpq_pkg::t_rec              i_rec,
    input  wire logic [ckpq_pkg::IdxW-1:0]   i_idx,
    output ckpq_pkg::t_rec                   o_best_rec,
    output logic      [ckpq_pkg::IdxW-1:0]   o_best_idx
);

    ckpq_pkg::t_rec            r_best_rec;
    logic [ckpq_pkg::IdxW-1:0] r_best_idx;
    logic                      take;

    // Take the first entry, then any entry that beats the current best
    assign take = i_ctl.cmp_en && (i_ctl.first || ckpq_pkg::goes_first(i_rec, r_best_rec));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_rec <= i_rec;
            r_best_idx <= i_idx;
        end
    end

    assign o_best_rec = r_best_rec;
    assign o_best_idx = r_best_idx;

endmodule

`default_nettype wire

// ===== rtl/composite_key_priority_queue_core.sv =====
// Top level: bounded priority queue of event records held in one RAM.
//
//  channel | dir | port  | transfer fields
//  --------+-----+-------+--------------------------------------------------
//  request | in  | i_req | op, urgent, hour, minute, kind, tag
//  result  | out | o_rsp | status, out_urgent, out_hour, out_minute,
//          |     |       | out_kind, out_tag, occupancy
//
//  A push passes the push and finish states; a pop on an empty queue goes to finish,
//  and a pop of stored records passes scan, drain, move and finish: the record RAM has
//  one port, so the scan reads one entry per cycle, then the last entry is moved into the hole.
//  One item is worked on at a time; the next request transfers while a result waits.
//  A stalled result holds the sequencer in its finish state; reset empties the queue.
`default_nettype none

module composite_key_priority_queue_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ckpq_req_if.sink   i_req,
    ckpq_rsp_if.source o_rsp
);

    localparam int unsigned IdxW = ckpq_pkg::IdxW;
    localparam int unsigned CntW = ckpq_pkg::CntW;
    localparam int unsigned SeqW = ckpq_pkg::SeqW;

    ckpq_pkg::t_state r_state, n_state;

    logic [CntW-1:0]           r_count, n_count;
    logic [SeqW-1:0]           r_seq, n_seq;
    logic [IdxW-1:0]           r_addr, n_addr;
    logic                      r_rd_valid, n_rd_valid;
    logic [IdxW-1:0]           r_rd_idx, n_rd_idx;
    ckpq_pkg::t_rec            r_item, n_item;
    ckpq_pkg::t_rsp            r_res, n_res;
    ckpq_pkg::t_rsp            r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic                      ram_we;
    logic [IdxW-1:0]           ram_addr;
    ckpq_pkg::t_rec            ram_wdata;
    ckpq_pkg::t_rec            ram_rdata;
    ckpq_pkg::t_best_ctl       best_ctl;
    ckpq_pkg::t_rec            best_rec;
    logic [IdxW-1:0]           best_idx;

    logic                      req_xfer;
    logic [CntW-1:0]           last_cnt;
    ckpq_pkg::t_rec            in_rec;

    assign req_xfer = i_req.valid && i_req.ready;
    assign last_cnt = r_count - CntW'(1);

    // Normalise an incoming record
    always_comb begin
        in_rec        = '0;
        in_rec.urgent = i_req.urgent;
        in_rec.hour   = (i_req.hour <= ckpq_pkg::HourMax) ? i_req.hour : 5'd0;
        in_rec.minute = (i_req.minute <= ckpq_pkg::MinuteMax) ? i_req.minute : 6'd0;
        in_rec.kind   = (i_req.kind == ckpq_pkg::KindUnused) ? ckpq_pkg::KindApp : i_req.kind;
        in_rec.tag    = i_req.tag[ckpq_pkg::TagW-1:0];
        in_rec.seq    = '0;
    end

    // Record store
    ckpq_ram #(
        .WIDTH (ckpq_pkg::RecW),
        .DEPTH (ckpq_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Best entry of the current scan
    assign best_ctl.cmp_en = r_rd_valid;
    assign best_ctl.first  = (r_rd_idx == '0);

    ckpq_best u_best (
        .i_clk      (i_clk),
        .i_ctl      (best_ctl),
        .i_rec      (ram_rdata),
        .i_idx      (r_rd_idx),
        .o_best_rec (best_rec),
        .o_best_idx (best_idx)
    );

    // Sequencer: next state, RAM access and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_seq       = r_seq;
        n_addr      = r_addr;
        n_rd_valid  = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_item      = r_item;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_addr    = r_addr;
        ram_wdata   = r_item;
        i_req.ready = 1'b0;

        unique case (r_state)
            ckpq_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (req_xfer) begin
                    n_item = in_rec;
                    n_addr = '0;
                    if (i_req.op == ckpq_pkg::OpPush) begin
                        n_state = ckpq_pkg::S_PUSH;
                    end else if (r_count == '0) begin
                        n_res        = '0;
                        n_res.status = ckpq_pkg::StatusEmpty;
                        n_state      = ckpq_pkg::S_FINISH;
                    end else begin
                        n_state = ckpq_pkg::S_SCAN;
                    end
                end
            end
            ckpq_pkg::S_PUSH: begin
                n_res = '0;
                if (r_count == CntW'(ckpq_pkg::CAPACITY)) begin
                    n_res.status    = ckpq_pkg::StatusFull;
                    n_res.occupancy = 5'(r_count);
                end else begin
                    ram_we          = 1'b1;
                    ram_addr        = r_count[IdxW-1:0];
                    ram_wdata       = r_item;
                    ram_wdata.seq   = r_seq;
                    n_count         = r_count + CntW'(1);
                    n_seq           = r_seq + SeqW'(1);
                    n_res.status    = ckpq_pkg::StatusOk;
                    n_res.occupancy = 5'(r_count + CntW'(1));
                end
                n_state = ckpq_pkg::S_FINISH;
            end
            ckpq_pkg::S_SCAN: begin
                ram_addr   = r_addr;
                n_rd_valid = 1'b1;
                n_rd_idx   = r_addr;
                if (r_addr == last_cnt[IdxW-1:0]) begin
                    n_state = ckpq_pkg::S_DRAIN;
                end else begin
                    n_addr = r_addr + IdxW'(1);
                end
            end
            ckpq_pkg::S_DRAIN: begin
                // Last compare lands now; fetch the last entry for the refill
                ram_addr = last_cnt[IdxW-1:0];
                n_state  = ckpq_pkg::S_MOVE;
            end
            ckpq_pkg::S_MOVE: begin
                ram_we          = 1'b1;
                ram_addr        = best_idx;
                ram_wdata       = ram_rdata;
                n_count         = last_cnt;
                n_res.status    = ckpq_pkg::StatusOk;
                n_res.urgent    = best_rec.urgent;
                n_res.hour      = best_rec.hour;
                n_res.minute    = best_rec.minute;
                n_res.kind      = best_rec.kind;
                n_res.tag       = best_rec.tag;
                n_res.occupancy = 5'(last_cnt);
                n_state         = ckpq_pkg::S_FINISH;
            end
            ckpq_pkg::S_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ckpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ckpq_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: load on finish, drop on transfer
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == ckpq_pkg::S_FINISH && (!r_out_valid || o_rsp.ready)) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end
    end

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ckpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_seq       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_seq       <= n_seq;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rd_idx <= n_rd_idx;
        r_item   <= n_item;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // Drive the result channel
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.out_urgent = r_out.urgent;
    assign o_rsp.out_hour   = r_out.hour;
    assign o_rsp.out_minute = r_out.minute;
    assign o_rsp.out_kind   = r_out.kind;
    assign o_rsp.out_tag    = 16'(r_out.tag);
    assign o_rsp.occupancy  = r_out.occupancy;

endmodule

`default_nettype wire
